/* design/csma_pkg.sv */
// shared types and constants for the checked scaled mass arithmetic unit
// no dependencies
package csma_pkg;

  localparam int DATA_WIDTH = 64;
  localparam int DIV_STEPS  = 128;

  // largest positive result and magnitude of the most negative result
  localparam logic [63:0] MAX_POS = (64'd1 << (DATA_WIDTH - 1)) - 64'd1;
  localparam logic [63:0] MIN_MAG = 64'd1 << (DATA_WIDTH - 1);
  localparam logic signed [64:0] MAX_S = $signed({1'b0, MAX_POS});
  localparam logic signed [64:0] MIN_S = -$signed({1'b0, MIN_MAG});

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_SUB  = 2'd1,
    OP_MDIV = 2'd2,
    OP_QUANT = 2'd3
  } op_t;

  // control that travels alongside an item
  typedef struct packed {
    op_t         op;
    logic        ok;
    logic        neg;
    logic [63:0] val;
    logic [63:0] dmag;
  } ctl_t;

  // partial remainder and numerator/quotient shift word
  typedef struct packed {
    logic [63:0]  rem;
    logic [127:0] num;
  } div_t;

  // take the low DATA_WIDTH bits, sign-extended
  function automatic logic [63:0] sext(input logic [63:0] x);
    logic signed [63:0] t;
    t = $signed(x << (64 - DATA_WIDTH));
    return 64'(t >>> (64 - DATA_WIDTH));
  endfunction

  function automatic logic [63:0] mag(input logic [63:0] x);
    return x[63] ? (~x + 64'd1) : x;
  endfunction

endpackage

/* design/csma_mul.sv */
// two-stage 64x64 unsigned multiplier built from 32x32 partial products
// depends on nothing but its ports
module csma_mul (
  input  logic         clk,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic [127:0] p
);

  logic [63:0] ll, lh, hl, hh;

  always_ff @(posedge clk) begin
    ll <= a[31:0] * b[31:0];
    lh <= a[31:0] * b[63:32];
    hl <= a[63:32] * b[31:0];
    hh <= a[63:32] * b[63:32];
  end

  always_ff @(posedge clk) begin
    p <= {64'd0, ll} + ({64'd0, lh} << 32) + ({64'd0, hl} << 32) + {hh, 64'd0};
  end

endmodule

/* design/csma_div_cell.sv */
// one restoring division step: shifts in one numerator bit, yields one quotient bit
// depends on csma_pkg
module csma_div_cell
  import csma_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  ctl_t in_ctl,
  input  div_t in_div,
  output logic out_valid,
  output ctl_t out_ctl,
  output div_t out_div
);

  logic [64:0] t;
  logic        ge;
  logic [64:0] diff;

  always_comb begin
    t    = {in_div.rem, in_div.num[127]};
    ge   = t >= {1'b0, in_ctl.dmag};
    diff = t - {1'b0, in_ctl.dmag};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_ctl     <= in_ctl;
    out_div.rem <= ge ? diff[63:0] : t[63:0];
    out_div.num <= {in_div.num[126:0], ge};
  end

endmodule

/* design/checked_scaled_mass_arithmetic.sv */
// top level of the checked scaled mass arithmetic unit
// depends on csma_pkg, csma_mul and csma_div_cell
//
// Takes one beat per clock (busy is always low) and returns one result beat
// per input beat, in order, marked by done for one cycle; the receiver
// cannot stall. The path runs through an input stage, a two-stage multiplier
// ahead of the divider, the 128-cell restoring divider chain (one quotient
// bit per cell per cycle), a rounding stage, a second two-stage multiplier
// for quantize and the output register. ok low means overflow, a zero
// divisor or (quantize) a step that is not positive, and result_value is
// then zero.
module checked_scaled_mass_arithmetic
  import csma_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         op,
  input  logic signed [63:0] first_operand,
  input  logic signed [63:0] second_operand,
  input  logic signed [63:0] divisor,
  output logic               done,
  output logic               ok,
  output logic signed [63:0] result_value
);

  // every stage advances each cycle, so the unit never pushes back
  assign busy = 1'b0;

  // input stage: add/sub with range check, operand magnitudes for the multiplier
  logic [63:0] a, b, d;
  logic signed [64:0] sum;
  ctl_t        ctl_in;
  logic [63:0] ma_in, mb_in;

  always_comb begin
    a      = sext(first_operand);
    b      = sext(second_operand);
    d      = sext(divisor);
    ctl_in = '0;
    ctl_in.op   = op_t'(op);
    ctl_in.dmag = mag(d);
    ma_in  = mag(a);
    mb_in  = mag(b);
    sum    = '0;
    unique case (op_t'(op))
      OP_ADD: begin
        sum = $signed({a[63], a}) + $signed({b[63], b});
        ctl_in.ok  = (sum <= MAX_S) && (sum >= MIN_S);
        ctl_in.val = sum[63:0];
      end
      OP_SUB: begin
        sum = $signed({a[63], a}) - $signed({b[63], b});
        ctl_in.ok  = (sum <= MAX_S) && (sum >= MIN_S);
        ctl_in.val = sum[63:0];
      end
      OP_MDIV: begin
        ctl_in.ok  = d != 64'd0;
        ctl_in.neg = a[63] ^ b[63] ^ d[63];
      end
      default: begin
        // quantize: divide |value| by a positive step first
        ctl_in.ok  = !d[63] && (d != 64'd0);
        ctl_in.neg = a[63];
        mb_in      = 64'd1;
      end
    endcase
  end

  logic        s0_valid;
  ctl_t        s0_ctl;
  logic [63:0] s0_ma, s0_mb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= start;
    end
  end

  always_ff @(posedge clk) begin
    s0_ctl <= ctl_in;
    s0_ma  <= ma_in;
    s0_mb  <= mb_in;
  end

  // exact 128-bit product of the magnitudes
  logic [127:0] prod;
  logic         m1_valid, m2_valid;
  ctl_t         m1_ctl, m2_ctl;

  csma_mul u_mul_a (
    .clk (clk),
    .a   (s0_ma),
    .b   (s0_mb),
    .p   (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
      m2_valid <= 1'b0;
    end else begin
      m1_valid <= s0_valid;
      m2_valid <= m1_valid;
    end
  end

  always_ff @(posedge clk) begin
    m1_ctl <= s0_ctl;
    m2_ctl <= m1_ctl;
  end

  // divider chain: each cell retires one quotient bit per beat
  logic cv [0:DIV_STEPS];
  ctl_t cc [0:DIV_STEPS];
  div_t cd [0:DIV_STEPS];

  assign cv[0]     = m2_valid;
  assign cc[0]     = m2_ctl;
  assign cd[0].rem = 64'd0;
  assign cd[0].num = prod;

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
    csma_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cv[i]),
      .in_ctl    (cc[i]),
      .in_div    (cd[i]),
      .out_valid (cv[i+1]),
      .out_ctl   (cc[i+1]),
      .out_div   (cd[i+1])
    );
  end

  // rounding stage: half away from zero, quotient range, sign
  ctl_t        dq;
  logic [63:0] quo, qf;
  logic        over, rnd, qok;

  always_comb begin
    dq   = cc[DIV_STEPS];
    quo  = cd[DIV_STEPS].num[63:0];
    over = |cd[DIV_STEPS].num[127:64];
    // remainder at least half the divisor rounds up
    rnd  = {cd[DIV_STEPS].rem, 1'b0} >= {1'b0, dq.dmag};
    qf   = quo + {63'd0, rnd};
    qok  = !over && !(rnd && (&quo)) && (dq.neg ? (qf <= MIN_MAG) : (qf <= MAX_POS));
    if (dq.op == OP_MDIV) begin
      dq.ok  = dq.ok && qok;
      dq.val = dq.neg ? (~qf + 64'd1) : qf;
    end else if (dq.op == OP_QUANT) begin
      dq.ok  = dq.ok && qok;
    end
  end

  logic        r_valid;
  ctl_t        r_ctl;
  logic [63:0] r_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else begin
      r_valid <= cv[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    r_ctl <= dq;
    r_q   <= qf;
  end

  // quantize: unit count times step
  logic [127:0] prod2;
  logic         n1_valid, n2_valid;
  ctl_t         n1_ctl, n2_ctl;

  csma_mul u_mul_b (
    .clk (clk),
    .a   (r_q),
    .b   (r_ctl.dmag),
    .p   (prod2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      n1_valid <= 1'b0;
      n2_valid <= 1'b0;
    end else begin
      n1_valid <= r_valid;
      n2_valid <= n1_valid;
    end
  end

  always_ff @(posedge clk) begin
    n1_ctl <= r_ctl;
    n2_ctl <= n1_ctl;
  end

  // final range check and output register
  logic        f_ok;
  logic [63:0] f_val;

  always_comb begin
    f_ok  = n2_ctl.ok;
    f_val = n2_ctl.val;
    if (n2_ctl.op == OP_QUANT) begin
      f_ok  = n2_ctl.ok && (prod2[127:64] == 64'd0) &&
              (n2_ctl.neg ? (prod2[63:0] <= MIN_MAG) : (prod2[63:0] <= MAX_POS));
      f_val = n2_ctl.neg ? (~prod2[63:0] + 64'd1) : prod2[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= n2_valid;
    end
  end

  always_ff @(posedge clk) begin
    ok           <= f_ok;
    result_value <= f_ok ? $signed(f_val) : 64'sd0;
  end

endmodule

/* tb/testbench.sv */
// self-checking testbench for checked_scaled_mass_arithmetic
// depends on csma_pkg and the rtl of the block; drives a directed table then random beats
`timescale 1ns / 100ps

module testbench;
  import csma_pkg::*;

  // drain margin beyond the pipeline depth of the block
  localparam int DRAIN_CYCLES = 160;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int N_RANDOM = 430;
  localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MOST_POS = 64'h7fff_ffff_ffff_ffff;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] op = OP_ADD;
  logic signed [63:0] first_operand = '0;
  logic signed [63:0] second_operand = '0;
  logic signed [63:0] divisor = '0;
  logic done;
  logic ok;
  logic signed [63:0] result_value;

  typedef struct {
    logic        ok;
    logic [63:0] value;
  } mass_result_t;

  // one directed row: operands, and a typed-in answer where one is obvious
  typedef struct {
    op_t         op;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] d;
    bit          literal;
    logic        ok;
    logic [63:0] value;
  } mass_row_t;

  mass_result_t pending_results[$];
  int error_count = 0;
  int idle_cycles = 0;
  int sender_idle_pct = 13;
  bit stimulus_done = 1'b0;

  checked_scaled_mass_arithmetic dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .first_operand(first_operand), .second_operand(second_operand),
    .divisor(divisor), .done(done), .ok(ok), .result_value(result_value)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // predictor of the block
  // ---------------------------------------------------------------------

  function automatic logic [63:0] abs_mag(input logic [63:0] x);
    return x[63] ? (~x + 64'd1) : x;
  endfunction

  // magnitude product divided by a magnitude, rounded half away from zero;
  // fails on a zero divisor or a quotient that does not fit in 64 bits
  function automatic bit round_divide(input logic [127:0] num, input logic [63:0] den,
                                      output logic [63:0] quo);
    logic [127:0] q128;
    logic [127:0] r128;
    quo = '0;
    if (den == 0) return 0;
    q128 = num / {64'd0, den};
    r128 = num % {64'd0, den};
    if (q128[127:64] != 0) return 0;
    if (r128 != 0 && r128 >= {64'd0, den} - r128) begin
      if (q128[63:0] == '1) return 0;
      q128 = q128 + 1;
    end
    quo = q128[63:0];
    return 1;
  endfunction

  function automatic bit scaled_mass_muldiv(input logic [63:0] v, input logic [63:0] m,
                                            input logic [63:0] d, output logic [63:0] res);
    logic [63:0] q;
    bit negative;
    res = '0;
    if (d == 0) return 0;
    negative = (v[63] ^ m[63]) ^ d[63];
    if (!round_divide({64'd0, abs_mag(v)} * {64'd0, abs_mag(m)}, abs_mag(d), q)) return 0;
    if (negative) begin
      if (q > MOST_NEG) return 0;
      res = -q;
    end else begin
      if (q > MOST_POS) return 0;
      res = q;
    end
    return 1;
  endfunction

  function automatic mass_result_t predict_mass(input op_t code, input logic [63:0] a,
                                                input logic [63:0] b, input logic [63:0] d);
    mass_result_t r;
    logic signed [64:0] wide;
    logic [63:0] units;
    r.ok = 1'b0;
    r.value = '0;
    case (code)
      OP_ADD: begin
        wide = $signed({a[63], a}) + $signed({b[63], b});
        r.ok = (wide[64] == wide[63]);
        r.value = wide[63:0];
      end
      OP_SUB: begin
        wide = $signed({a[63], a}) - $signed({b[63], b});
        r.ok = (wide[64] == wide[63]);
        r.value = wide[63:0];
      end
      OP_MDIV: r.ok = scaled_mass_muldiv(a, b, d, r.value);
      default: begin
        // step must be positive; divide to a count, then scale back
        r.ok = !d[63] && d != 0 && scaled_mass_muldiv(a, 64'd1, d, units)
               && scaled_mass_muldiv(units, d, 64'd1, r.value);
      end
    endcase
    if (!r.ok) r.value = '0;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    error_count++;
  endtask

  always @(posedge clk) begin
    mass_result_t want;
    if (!rst && done) begin
      idle_cycles <= 0;
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (ok !== want.ok)
          report_mismatch($sformatf("ok %b, expected %b", ok, want.ok));
        if (result_value !== want.value)
          report_mismatch($sformatf("result_value %h, expected %h",
                                    result_value, want.value));
      end
    end else if (!rst && start && !busy) begin
      idle_cycles <= 0;
    end else if (!rst) begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // watchdog: too long without any accepted beat or result beat
  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout waiting for beats");
      $display("testbench: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------

  // drive one beat at the falling edge and hold it until accepted
  task automatic send_beat(input op_t code, input logic [63:0] a, input logic [63:0] b,
                           input logic [63:0] d);
    while ($urandom_range(99, 0) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    op <= code;
    first_operand <= a;
    second_operand <= b;
    divisor <= d;
    pending_results.push_back(predict_mass(code, a, b, d));
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [63:0] random_word();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(7, 0))
      0: w = $urandom_range(1, 0) ? MOST_NEG : MOST_POS;
      1: w = $signed($urandom_range(40, 0)) - 20;       // near zero
      2: w = {{32{w[31]}}, w[31:0]};                    // moderate size
      3: w = {{48{w[15]}}, w[15:0]};
      default: ;
    endcase
    return w;
  endfunction

  mass_row_t directed[] = '{
    // add / subtract extremes and overflow
    '{OP_ADD, MOST_POS, 64'd0, 64'd0, 1, 1'b1, MOST_POS},
    '{OP_ADD, MOST_POS, 64'd1, 64'd0, 1, 1'b0, 64'd0},
    '{OP_ADD, MOST_NEG, -64'sd1, 64'd0, 1, 1'b0, 64'd0},
    '{OP_ADD, MOST_NEG, MOST_POS, 64'd0, 1, 1'b1, -64'sd1},
    '{OP_SUB, MOST_NEG, 64'd1, 64'd0, 1, 1'b0, 64'd0},
    '{OP_SUB, 64'd0, MOST_NEG, 64'd0, 1, 1'b0, 64'd0},
    '{OP_SUB, -64'sd1, MOST_NEG, 64'd0, 1, 1'b1, MOST_POS},
    // multiply-divide: zero divisor, rounding ties, sign handling, wide product
    '{OP_MDIV, 64'd5, 64'd7, 64'd0, 1, 1'b0, 64'd0},
    '{OP_MDIV, 64'd5, 64'd1, 64'd2, 1, 1'b1, 64'd3},
    '{OP_MDIV, -64'sd5, 64'd1, 64'd2, 1, 1'b1, -64'sd3},
    '{OP_MDIV, 64'd5, 64'd1, -64'sd2, 1, 1'b1, -64'sd3},
    '{OP_MDIV, 64'd7, 64'd1, 64'd3, 1, 1'b1, 64'd2},
    '{OP_MDIV, MOST_POS, MOST_POS, MOST_POS, 1, 1'b1, MOST_POS},
    '{OP_MDIV, MOST_NEG, 64'd1, 64'd1, 1, 1'b1, MOST_NEG},
    '{OP_MDIV, MOST_NEG, -64'sd1, 64'd1, 1, 1'b0, 64'd0},
    '{OP_MDIV, MOST_NEG, MOST_NEG, 64'd1, 1, 1'b0, 64'd0},
    '{OP_MDIV, MOST_NEG, MOST_NEG, MOST_NEG, 0, 1'b0, 64'd0},
    '{OP_MDIV, MOST_POS, 64'd3, 64'd2, 0, 1'b0, 64'd0},
    // quantize: bad steps, ties, and a count that cannot scale back
    '{OP_QUANT, 64'd17, 64'd0, 64'd0, 1, 1'b0, 64'd0},
    '{OP_QUANT, 64'd17, 64'd0, -64'sd5, 1, 1'b0, 64'd0},
    '{OP_QUANT, 64'd15, 64'd0, 64'd10, 1, 1'b1, 64'd20},
    '{OP_QUANT, -64'sd15, MOST_NEG, 64'd10, 1, 1'b1, -64'sd20},
    '{OP_QUANT, MOST_POS, 64'd0, 64'd10, 1, 1'b0, 64'd0},
    '{OP_QUANT, MOST_NEG, 64'd0, MOST_POS, 0, 1'b0, 64'd0},
    '{OP_QUANT, MOST_POS, MOST_POS, 64'd1, 1, 1'b1, MOST_POS}
  };

  initial begin
    mass_result_t want;
    op_t code;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] d;
    logic [63:0] q;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table; typed-in answers must agree with the predictor too
    foreach (directed[i]) begin
      want = predict_mass(directed[i].op, directed[i].a, directed[i].b, directed[i].d);
      if (directed[i].literal &&
          (want.ok !== directed[i].ok || want.value !== directed[i].value))
        report_mismatch($sformatf("row %0d: table disagrees with predictor", i));
      send_beat(directed[i].op, directed[i].a, directed[i].b, directed[i].d);
    end

    // random part in three idling phases: light, heavy, none
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 67 : 0;
      for (int n = 0; n < N_RANDOM / 3; n++) begin
        code = op_t'($urandom_range(3, 0));
        a = random_word();
        b = random_word();
        d = random_word();
        // keep many divide cases in range so the rounding path gets exercised
        if (code != OP_ADD && code != OP_SUB && $urandom_range(3, 0) != 0) begin
          q = {{32{1'b0}}, $urandom} | 64'd1;
          d = $urandom_range(1, 0) ? q : -q;
          if (code == OP_QUANT) d = q;
        end
        send_beat(code, a, b, d);
      end
    end
    start <= 1'b0;
    stimulus_done = 1'b1;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/csma_pkg.sv
design/csma_mul.sv
design/csma_div_cell.sv
design/checked_scaled_mass_arithmetic.sv
tb/testbench.sv
